// ===== design/mds_pkg.sv =====
// Shared constants, codes and types of the divisor-sum query block.
// Used by the channel interfaces, the datapath, the controller and the top level.
package mds_pkg;

   localparam int TABLE_LIMIT = 65536;
   localparam int TABLE_DEPTH = TABLE_LIMIT + 1;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int PRIME_DEPTH = TABLE_LIMIT / 2 + 8;
   localparam int PRIME_W     = $clog2(PRIME_DEPTH);
   localparam int BOUND_W     = 17;
   localparam int WIDE_W      = (ADDR_W > BOUND_W ? ADDR_W : BOUND_W) + 1;
   localparam int ANSWER_W    = 63;
   localparam int SUM_W       = 64;
   localparam int D_W         = 8;
   localparam int E_W         = 5;
   localparam int MPRE_W      = 16;
   localparam int DPRE_W      = ADDR_W + 5;
   localparam int PROD_W      = 2 * DPRE_W;
   localparam int DIFF_W      = MPRE_W + 1;
   localparam int TERM_W      = DIFF_W + PROD_W + 1;
   localparam int QPROD_W     = CNT_W + ADDR_W;

   localparam logic CMD_BUILD = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic signed [1:0] MU_ZERO = 2'sb00;
   localparam logic signed [1:0] MU_POS  = 2'sb01;
   localparam logic signed [1:0] MU_NEG  = 2'sb11;

   // per-number sieve record; divisor count is rest * (expo + 1)
   typedef struct packed {
      logic                     comp;
      logic signed [1:0]        mu;
      logic        [D_W-1:0]    rest;
      logic        [E_W-1:0]    expo;
      logic        [ADDR_W-1:0] lpf;
   } info_type;

   localparam int INFO_W = $bits(info_type);

   typedef enum logic [1:0] {
      DIV_QN = 2'd0,
      DIV_QM = 2'd1,
      DIV_A  = 2'd2,
      DIV_B  = 2'd3
   } div_sel_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_CLEAR,
      OP_SEED,
      OP_BCHECK,
      OP_PGET,
      OP_PMUL,
      OP_MARK,
      OP_BNEXT,
      OP_PINIT,
      OP_SACC,
      OP_BDONE,
      OP_ZERO,
      OP_QINIT,
      OP_DIV,
      OP_DWAIT,
      OP_QRD1,
      OP_QRD2,
      OP_QMUL1,
      OP_QMUL2,
      OP_QACC,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type   op;
      div_sel_type sel;
   } dp_cmd_type;

   typedef struct packed {
      logic is_query;
      logic skip;
      logic clr_last;
      logic idx_end;
      logic k_end;
      logic q_over;
      logic p_hit;
      logic div_done;
      logic q_last;
      logic out_free;
   } dp_stat_type;

endpackage

// ===== design/mds_if.sv =====
// Request and response channel interfaces with valid/ready handshake.
// Depends on mds_pkg for the field widths.
interface mds_req_if import mds_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               command;
   logic [BOUND_W-1:0] first_bound;
   logic [BOUND_W-1:0] second_bound;

   modport source (output valid, output command, output first_bound,
                   output second_bound, input ready);
   modport sink (input valid, input command, input first_bound,
                 input second_bound, output ready);
endinterface

interface mds_rsp_if import mds_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ANSWER_W-1:0] answer;

   modport source (output valid, output answer, input ready);
   modport sink (input valid, input answer, output ready);
endinterface

// ===== design/mds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/mds_divider.sv =====
// Restoring divider, one quotient bit per cycle, done pulses with the quotient.
// Depends on mds_pkg for the operand width.
module mds_divider import mds_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [ADDR_W-1:0] dividend,
   input  logic [ADDR_W-1:0] divisor,
   output logic              done,
   output logic [ADDR_W-1:0] quotient
);
   localparam int STEP_W = $clog2(ADDR_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_W:0]   rem_ff, rem_in;
   logic [ADDR_W-1:0] quo_ff, quo_in;
   logic [ADDR_W-1:0] den_ff, den_in;
   logic [ADDR_W:0]   rem_sh;

   assign rem_sh = {rem_ff[ADDR_W-1:0], quo_ff[ADDR_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = STEP_W'(ADDR_W);
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[ADDR_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[ADDR_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== design/mds_datapath.sv =====
// Datapath: sieve record, prime list and prefix-sum memories, divider,
// query accumulator and output register. Depends on mds_pkg, mds_ram, mds_divider.
module mds_datapath import mds_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_stat_type         stat,
   input  logic                req_command,
   input  logic [BOUND_W-1:0]  req_first_bound,
   input  logic [BOUND_W-1:0]  req_second_bound,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [ANSWER_W-1:0] rsp_answer
);
   logic                       cmd_ff, cmd_in;
   logic                       built_ff, built_in;
   logic [ADDR_W-1:0]          n_ff, n_in, m_ff, m_in;
   logic [CNT_W-1:0]           idx_ff, idx_in;
   logic [PRIME_W-1:0]         k_ff, k_in, pcount_ff, pcount_in;
   logic [ADDR_W-1:0]          p_ff, p_in;
   logic [QPROD_W-1:0]         q_ff, q_in;
   logic signed [1:0]          mu_i_ff, mu_i_in;
   logic [D_W-1:0]             rest_i_ff, rest_i_in;
   logic [E_W-1:0]             exp_i_ff, exp_i_in;
   logic [ADDR_W-1:0]          lpf_i_ff, lpf_i_in;
   logic signed [MPRE_W-1:0]   macc_ff, macc_in;
   logic [DPRE_W-1:0]          dacc_ff, dacc_in;
   logic [ADDR_W-1:0]          qn_ff, qn_in, qm_ff, qm_in, a_ff, a_in, b_ff, b_in;
   logic signed [MPRE_W-1:0]   prevm_ff, prevm_in;
   logic signed [DIFF_W-1:0]   diff_ff, diff_in;
   logic [DPRE_W-1:0]          dqn_ff, dqn_in;
   logic [PROD_W-1:0]          prodd_ff, prodd_in;
   logic signed [TERM_W-1:0]   term_ff, term_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic                       out_valid_ff, out_valid_in;
   logic [ANSWER_W-1:0]        answer_ff, answer_in;

   logic                       info_we;
   logic [ADDR_W-1:0]          info_waddr;
   info_type                   info_wr, info_rd;
   logic [INFO_W-1:0]          info_rdata;
   logic                       prime_we;
   logic [ADDR_W-1:0]          prime_rdata;
   logic                       pre_we;
   logic [ADDR_W-1:0]          pre_waddr;
   logic [ADDR_W-1:0]          mpre_raddr, dpre_raddr;
   logic [MPRE_W-1:0]          mpre_rdata;
   logic [DPRE_W-1:0]          dpre_rdata;
   logic                       div_start, div_done;
   logic [ADDR_W-1:0]          div_dividend, div_divisor, div_quotient;
   logic [ADDR_W-1:0]          first_sat, second_sat, next_blk;
   logic [D_W+E_W:0]           d_i_full, d_rd_full;
   logic [D_W-1:0]             d_i, d_rd;

   assign first_sat = (WIDE_W'(req_first_bound) > WIDE_W'(TABLE_LIMIT))
                      ? ADDR_W'(TABLE_LIMIT) : ADDR_W'(req_first_bound);
   assign second_sat = (WIDE_W'(req_second_bound) > WIDE_W'(TABLE_LIMIT))
                       ? ADDR_W'(TABLE_LIMIT) : ADDR_W'(req_second_bound);
   assign next_blk  = (a_ff < b_ff) ? a_ff : b_ff;
   assign info_rd   = info_type'(info_rdata);
   assign d_i_full  = rest_i_ff * ({1'b0, exp_i_ff} + (E_W+1)'(1));
   assign d_i       = d_i_full[D_W-1:0];
   assign d_rd_full = info_rd.rest * ({1'b0, info_rd.expo} + (E_W+1)'(1));
   assign d_rd      = d_rd_full[D_W-1:0];

   always_comb begin
      cmd_in       = cmd_ff;
      built_in     = built_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      pcount_in    = pcount_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      mu_i_in      = mu_i_ff;
      rest_i_in    = rest_i_ff;
      exp_i_in     = exp_i_ff;
      lpf_i_in     = lpf_i_ff;
      macc_in      = macc_ff;
      dacc_in      = dacc_ff;
      qn_in        = qn_ff;
      qm_in        = qm_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      prevm_in     = prevm_ff;
      diff_in      = diff_ff;
      dqn_in       = dqn_ff;
      prodd_in     = prodd_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      answer_in    = answer_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      info_we      = 1'b0;
      info_waddr   = idx_ff[ADDR_W-1:0];
      info_wr      = '0;
      prime_we     = 1'b0;
      pre_we       = 1'b0;
      pre_waddr    = idx_ff[ADDR_W-1:0];
      mpre_raddr   = next_blk;
      dpre_raddr   = qn_ff;
      div_start    = 1'b0;
      case (cmd.sel)
         DIV_QN: begin
            div_dividend = n_ff;
            div_divisor  = idx_ff[ADDR_W-1:0];
         end
         DIV_QM: begin
            div_dividend = m_ff;
            div_divisor  = idx_ff[ADDR_W-1:0];
         end
         DIV_A: begin
            div_dividend = n_ff;
            div_divisor  = qn_ff;
         end
         default: begin
            div_dividend = m_ff;
            div_divisor  = qm_ff;
         end
      endcase
      case (cmd.op)
         OP_ACCEPT: begin
            cmd_in = req_command;
            idx_in = '0;
            if (first_sat <= second_sat) begin
               n_in = first_sat;
               m_in = second_sat;
            end else begin
               n_in = second_sat;
               m_in = first_sat;
            end
         end
         OP_CLEAR: begin
            info_we = 1'b1;
            idx_in  = idx_ff + 1'b1;
         end
         OP_SEED: begin
            info_we      = 1'b1;
            info_waddr   = ADDR_W'(1);
            info_wr.comp = 1'b1;
            info_wr.mu   = MU_POS;
            info_wr.rest = D_W'(1);
            info_wr.lpf  = ADDR_W'(1);
            pcount_in    = '0;
            idx_in       = CNT_W'(2);
         end
         OP_BCHECK: begin
            k_in = '0;
            if (!info_rd.comp) begin
               // new prime: append and record it as its own least factor
               prime_we     = 1'b1;
               pcount_in    = pcount_ff + 1'b1;
               info_we      = 1'b1;
               info_wr.mu   = MU_NEG;
               info_wr.rest = D_W'(1);
               info_wr.expo = E_W'(1);
               info_wr.lpf  = idx_ff[ADDR_W-1:0];
               mu_i_in      = MU_NEG;
               rest_i_in    = D_W'(1);
               exp_i_in     = E_W'(1);
               lpf_i_in     = idx_ff[ADDR_W-1:0];
            end else begin
               mu_i_in   = info_rd.mu;
               rest_i_in = info_rd.rest;
               exp_i_in  = info_rd.expo;
               lpf_i_in  = info_rd.lpf;
            end
         end
         OP_PGET: p_in = prime_rdata;
         OP_PMUL: q_in = QPROD_W'(idx_ff * p_ff);
         OP_MARK: begin
            if (!stat.q_over) begin
               info_we      = 1'b1;
               info_waddr   = q_ff[ADDR_W-1:0];
               info_wr.comp = 1'b1;
               info_wr.lpf  = p_ff;
               if (stat.p_hit) begin
                  info_wr.mu   = MU_ZERO;
                  info_wr.rest = rest_i_ff;
                  info_wr.expo = exp_i_ff + 1'b1;
               end else begin
                  info_wr.mu   = -mu_i_ff;
                  info_wr.rest = d_i;
                  info_wr.expo = E_W'(1);
               end
               k_in = k_ff + 1'b1;
            end
         end
         OP_BNEXT: idx_in = idx_ff + 1'b1;
         OP_PINIT: begin
            pre_we    = 1'b1;
            pre_waddr = '0;
            macc_in   = '0;
            dacc_in   = '0;
            idx_in    = CNT_W'(1);
         end
         OP_SACC: begin
            macc_in = macc_ff + MPRE_W'(info_rd.mu);
            dacc_in = dacc_ff + DPRE_W'(d_rd);
            pre_we  = 1'b1;
            idx_in  = idx_ff + 1'b1;
         end
         OP_BDONE: begin
            built_in = 1'b1;
            sum_in   = '0;
         end
         OP_ZERO: sum_in = '0;
         OP_QINIT: begin
            idx_in   = CNT_W'(1);
            sum_in   = '0;
            prevm_in = '0;
         end
         OP_DIV: div_start = 1'b1;
         OP_DWAIT: begin
            if (div_done) begin
               case (cmd.sel)
                  DIV_QN:  qn_in = div_quotient;
                  DIV_QM:  qm_in = div_quotient;
                  DIV_A:   a_in  = div_quotient;
                  default: b_in  = div_quotient;
               endcase
            end
         end
         OP_QRD2: begin
            diff_in    = DIFF_W'($signed(mpre_rdata)) - DIFF_W'(prevm_ff);
            prevm_in   = $signed(mpre_rdata);
            dqn_in     = dpre_rdata;
            dpre_raddr = qm_ff;
         end
         OP_QMUL1: prodd_in = dqn_ff * dpre_rdata;
         OP_QMUL2: term_in = diff_ff * $signed({1'b0, prodd_ff});
         OP_QACC: begin
            sum_in = sum_ff + SUM_W'(term_ff);
            idx_in = CNT_W'(next_blk) + 1'b1;
         end
         OP_OUT: begin
            out_valid_in = 1'b1;
            answer_in    = sum_ff[ANSWER_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         built_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         built_ff     <= built_in;
         out_valid_ff <= out_valid_in;
      end
      cmd_ff    <= cmd_in;
      n_ff      <= n_in;
      m_ff      <= m_in;
      idx_ff    <= idx_in;
      k_ff      <= k_in;
      pcount_ff <= pcount_in;
      p_ff      <= p_in;
      q_ff      <= q_in;
      mu_i_ff   <= mu_i_in;
      rest_i_ff <= rest_i_in;
      exp_i_ff  <= exp_i_in;
      lpf_i_ff  <= lpf_i_in;
      macc_ff   <= macc_in;
      dacc_ff   <= dacc_in;
      qn_ff     <= qn_in;
      qm_ff     <= qm_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      prevm_ff  <= prevm_in;
      diff_ff   <= diff_in;
      dqn_ff    <= dqn_in;
      prodd_ff  <= prodd_in;
      term_ff   <= term_in;
      sum_ff    <= sum_in;
      answer_ff <= answer_in;
   end

   mds_ram #(.WIDTH(INFO_W), .DEPTH(TABLE_DEPTH)) u_info_ram (
      .clock   (clock),
      .wr_en   (info_we),
      .wr_addr (info_waddr),
      .wr_data (info_wr),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (info_rdata)
   );

   mds_ram #(.WIDTH(ADDR_W), .DEPTH(PRIME_DEPTH)) u_prime_ram (
      .clock   (clock),
      .wr_en   (prime_we),
      .wr_addr (pcount_ff),
      .wr_data (idx_ff[ADDR_W-1:0]),
      .rd_addr (k_ff),
      .rd_data (prime_rdata)
   );

   mds_ram #(.WIDTH(MPRE_W), .DEPTH(TABLE_DEPTH)) u_mpre_ram (
      .clock   (clock),
      .wr_en   (pre_we),
      .wr_addr (pre_waddr),
      .wr_data (macc_in),
      .rd_addr (mpre_raddr),
      .rd_data (mpre_rdata)
   );

   mds_ram #(.WIDTH(DPRE_W), .DEPTH(TABLE_DEPTH)) u_dpre_ram (
      .clock   (clock),
      .wr_en   (pre_we),
      .wr_addr (pre_waddr),
      .wr_data (dacc_in),
      .rd_addr (dpre_raddr),
      .rd_data (dpre_rdata)
   );

   mds_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign stat.is_query = (cmd_ff == CMD_QUERY);
   assign stat.skip     = (n_ff == '0) || !built_ff;
   assign stat.clr_last = (idx_ff == CNT_W'(TABLE_LIMIT));
   assign stat.idx_end  = (idx_ff > CNT_W'(TABLE_LIMIT));
   assign stat.k_end    = (k_ff == pcount_ff);
   assign stat.q_over   = (q_ff > QPROD_W'(TABLE_LIMIT));
   assign stat.p_hit    = (p_ff == lpf_i_ff);
   assign stat.div_done = div_done;
   assign stat.q_last   = (next_blk >= n_ff);
   assign stat.out_free = !out_valid_ff || rsp_ready;

   assign rsp_valid  = out_valid_ff;
   assign rsp_answer = answer_ff;
endmodule

// ===== design/mds_ctrl.sv =====
// Controller: sequences clear, sieve, prefix sums and the query block loop.
// Depends on mds_pkg for the command and status types.
module mds_ctrl import mds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);
   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_CLEAR, S_SEED, S_BREAD, S_BCHECK, S_PREAD, S_PGET,
      S_PMUL, S_MARK, S_BNEXT, S_PINIT, S_SREAD, S_SACC, S_BDONE, S_ZERO,
      S_QINIT, S_DIV, S_DWAIT, S_QRD1, S_QRD2, S_QMUL1, S_QMUL2, S_QACC, S_OUT
   } state_type;

   state_type   state_ff, state_in;
   div_sel_type sel_ff, sel_in;

   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      cmd.op    = OP_NONE;
      cmd.sel   = sel_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_ACCEPT;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (!stat.is_query) begin
               state_in = S_CLEAR;
            end else if (stat.skip) begin
               state_in = S_ZERO;
            end else begin
               state_in = S_QINIT;
            end
         end
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (stat.clr_last) begin
               state_in = S_SEED;
            end
         end
         S_SEED: begin
            cmd.op   = OP_SEED;
            state_in = S_BREAD;
         end
         S_BREAD: state_in = stat.idx_end ? S_PINIT : S_BCHECK;
         S_BCHECK: begin
            cmd.op   = OP_BCHECK;
            state_in = S_PREAD;
         end
         S_PREAD: state_in = stat.k_end ? S_BNEXT : S_PGET;
         S_PGET: begin
            cmd.op   = OP_PGET;
            state_in = S_PMUL;
         end
         S_PMUL: begin
            cmd.op   = OP_PMUL;
            state_in = S_MARK;
         end
         S_MARK: begin
            // stop at the bound or right after the least prime of i
            cmd.op   = OP_MARK;
            state_in = (stat.q_over || stat.p_hit) ? S_BNEXT : S_PREAD;
         end
         S_BNEXT: begin
            cmd.op   = OP_BNEXT;
            state_in = S_BREAD;
         end
         S_PINIT: begin
            cmd.op   = OP_PINIT;
            state_in = S_SREAD;
         end
         S_SREAD: state_in = stat.idx_end ? S_BDONE : S_SACC;
         S_SACC: begin
            cmd.op   = OP_SACC;
            state_in = S_SREAD;
         end
         S_BDONE: begin
            cmd.op   = OP_BDONE;
            state_in = S_OUT;
         end
         S_ZERO: begin
            cmd.op   = OP_ZERO;
            state_in = S_OUT;
         end
         S_QINIT: begin
            cmd.op   = OP_QINIT;
            sel_in   = DIV_QN;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op   = OP_DIV;
            state_in = S_DWAIT;
         end
         S_DWAIT: begin
            cmd.op = OP_DWAIT;
            if (stat.div_done) begin
               case (sel_ff)
                  DIV_QN: begin
                     sel_in   = DIV_QM;
                     state_in = S_DIV;
                  end
                  DIV_QM: begin
                     sel_in   = DIV_A;
                     state_in = S_DIV;
                  end
                  DIV_A: begin
                     sel_in   = DIV_B;
                     state_in = S_DIV;
                  end
                  default: state_in = S_QRD1;
               endcase
            end
         end
         S_QRD1: begin
            cmd.op   = OP_QRD1;
            state_in = S_QRD2;
         end
         S_QRD2: begin
            cmd.op   = OP_QRD2;
            state_in = S_QMUL1;
         end
         S_QMUL1: begin
            cmd.op   = OP_QMUL1;
            state_in = S_QMUL2;
         end
         S_QMUL2: begin
            cmd.op   = OP_QMUL2;
            state_in = S_QACC;
         end
         S_QACC: begin
            cmd.op = OP_QACC;
            sel_in = DIV_QN;
            state_in = stat.q_last ? S_OUT : S_DIV;
         end
         S_OUT: begin
            // hold until the output register is free
            if (stat.out_free) begin
               cmd.op   = OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff   <= DIV_QN;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end
endmodule

// ===== design/mobius_divisor_sum_query.sv =====
// Top level of the divisor-count double sum block: controller plus datapath.
// Depends on mds_pkg, mds_if, mds_ctrl and mds_datapath.
//
// Usage: req_chan carries one item per beat: command 0 builds the tables, command 1
// queries with bounds first_bound and second_bound (each saturated to TABLE_LIMIT).
// rsp_chan returns exactly one answer per item: zero for a build, otherwise the sum
// of d(i*j) over i <= n, j <= m, reduced to 63 bits.
// One item is worked on at a time; req_chan.ready is high only while the block idles.
// A build runs a clearing sweep of the record memory, the linear sieve and a prefix
// pass over the table. A query walks the equal-quotient blocks (at most about
// 2*sqrt(n) + 2*sqrt(m) of them) and uses the shared bit-serial divider four times
// per block.
// Reset clears the controller and marks the tables as not built, so queries answer
// zero until the first build. The result sits in an output register; a stalled
// receiver does not stop the next item from being accepted, but that item's result
// waits until the held one is taken.
module mobius_divisor_sum_query import mds_pkg::*; (
   input logic       clock,
   input logic       reset,
   mds_req_if.sink   req_chan,
   mds_rsp_if.source rsp_chan
);
   dp_cmd_type  cmd;
   dp_stat_type stat;

   mds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mds_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_command      (req_chan.command),
      .req_first_bound  (req_chan.first_bound),
      .req_second_bound (req_chan.second_bound),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_answer       (rsp_chan.answer)
   );
endmodule

// ===== verif/mobius_divisor_sum_query_test.sv =====
// Self-checking testbench of the divisor-count double sum block (sieve build and queries).
// Depends on mds_pkg, mds_if and the mobius_divisor_sum_query top level.
module mobius_divisor_sum_query_test;
   import mds_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_QUERIES = 275;
   localparam int CALM_TAIL      = 40;
   localparam int STALL_AT       = 60;
   localparam int STALL_CYCLES   = 12000;
   localparam int WATCHDOG_LIMIT = 4000000;
   localparam int DRAIN_CYCLES   = 200;

   typedef struct {
      logic                command;
      logic [BOUND_W-1:0]  n;
      logic [BOUND_W-1:0]  m;
      bit                  known;
      logic [ANSWER_W-1:0] answer;
   } stim_row_type;

   logic clock;
   logic reset;

   mds_req_if req_chan ();
   mds_rsp_if rsp_chan ();

   mobius_divisor_sum_query u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predictor state
   bit     sieve_comp  [0:TABLE_LIMIT];
   int     prime_tab   [$];
   int     mu_tab      [0:TABLE_LIMIT];
   int     dcount_tab  [0:TABLE_LIMIT];
   int     lexp_tab    [0:TABLE_LIMIT];
   int     mu_prefix   [0:TABLE_LIMIT];
   longint dsum_prefix [0:TABLE_LIMIT];

   logic [ANSWER_W-1:0] pending_answers [$];
   int  accepted_items;
   int  total_items;
   int  mismatches;
   int  idle_cycles;
   int  stall_left;
   int  rsp_gap;
   bit  stall_done;

   stim_row_type directed_rows [] = '{
      '{CMD_QUERY, 17'd10, 17'd10, 1'b1, 63'd0},
      '{CMD_QUERY, 17'd0, 17'd0, 1'b1, 63'd0},
      '{CMD_BUILD, 17'h1ffff, 17'h1ffff, 1'b1, 63'd0},
      '{CMD_QUERY, 17'd0, 17'd5, 1'b1, 63'd0},
      '{CMD_QUERY, 17'd7, 17'd0, 1'b1, 63'd0},
      '{CMD_QUERY, 17'd0, 17'h1ffff, 1'b1, 63'd0},
      '{CMD_QUERY, 17'd1, 17'd1, 1'b1, 63'd1},
      '{CMD_QUERY, 17'd2, 17'd3, 1'b0, 63'd0},
      '{CMD_QUERY, 17'd3, 17'd2, 1'b0, 63'd0},
      '{CMD_QUERY, 17'd12, 17'd12, 1'b0, 63'd0},
      '{CMD_QUERY, 17'd65536, 17'd65536, 1'b0, 63'd0},
      '{CMD_QUERY, 17'h1ffff, 17'd5, 1'b0, 63'd0},
      '{CMD_QUERY, 17'd1, 17'h1ffff, 1'b0, 63'd0},
      '{CMD_BUILD, 17'd0, 17'd0, 1'b1, 63'd0},
      '{CMD_QUERY, 17'd20, 17'd10, 1'b0, 63'd0}
   };

   function automatic void clear_tables();
      for (int i = 0; i <= TABLE_LIMIT; i++) begin
         mu_prefix[i]   = 0;
         dsum_prefix[i] = 0;
      end
   endfunction

   function automatic void sieve_tables();
      int p;
      int q;
      for (int i = 0; i <= TABLE_LIMIT; i++) sieve_comp[i] = 1'b0;
      prime_tab.delete();
      mu_tab[0] = 0; dcount_tab[0] = 0; lexp_tab[0] = 0;
      mu_tab[1] = 1; dcount_tab[1] = 1; lexp_tab[1] = 0;
      sieve_comp[1] = 1'b1;
      for (int i = 2; i <= TABLE_LIMIT; i++) begin
         if (!sieve_comp[i]) begin
            prime_tab.push_back(i);
            lexp_tab[i] = 1; dcount_tab[i] = 2; mu_tab[i] = -1;
         end
         foreach (prime_tab[k]) begin
            p = prime_tab[k];
            if (longint'(i) * p > TABLE_LIMIT) break;
            q = i * p;
            sieve_comp[q] = 1'b1;
            if (i % p == 0) begin
               mu_tab[q]     = 0;
               dcount_tab[q] = dcount_tab[i] / (lexp_tab[i] + 1) * (lexp_tab[i] + 2);
               lexp_tab[q]   = lexp_tab[i] + 1;
               break;
            end
            mu_tab[q]     = -mu_tab[i];
            dcount_tab[q] = dcount_tab[i] * 2;
            lexp_tab[q]   = 1;
         end
      end
      mu_prefix[0] = 0; dsum_prefix[0] = 0;
      for (int i = 1; i <= TABLE_LIMIT; i++) begin
         mu_prefix[i]   = mu_prefix[i-1] + mu_tab[i];
         dsum_prefix[i] = dsum_prefix[i-1] + dcount_tab[i];
      end
   endfunction

   function automatic logic [ANSWER_W-1:0] divisor_pair_sum(int n_in, int m_in);
      int n, m, i, nxt, qn, qm, a, b;
      longint acc;
      n = n_in > TABLE_LIMIT ? TABLE_LIMIT : n_in;
      m = m_in > TABLE_LIMIT ? TABLE_LIMIT : m_in;
      if (n > m) begin
         i = n; n = m; m = i;
      end
      acc = 0;
      if (n == 0) return '0;
      i = 1;
      while (i <= n) begin
         qn = n / i; qm = m / i;
         a = n / qn; b = m / qm;
         nxt = a < b ? a : b;
         acc += longint'(mu_prefix[nxt] - mu_prefix[i-1]) * dsum_prefix[qn]
                * dsum_prefix[qm];
         i = nxt + 1;
      end
      return acc[ANSWER_W-1:0];
   endfunction

   // offer one item, hold until the beat, then maybe idle
   task automatic send_item(stim_row_type row);
      int gap;
      req_chan.valid        <= 1'b1;
      req_chan.command      <= row.command;
      req_chan.first_bound  <= row.n;
      req_chan.second_bound <= row.m;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      if (row.command == CMD_BUILD) sieve_tables();
      if (row.known) pending_answers.push_back(row.answer);
      else if (row.command == CMD_BUILD) pending_answers.push_back('0);
      else pending_answers.push_back(divisor_pair_sum(row.n, row.m));
      accepted_items++;
      if (accepted_items < total_items - CALM_TAIL && $urandom_range(3) == 0) begin
         gap = $urandom_range(11, 1);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stall bursts, one long hold-off, calm at the end
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b1;
         stall_left <= 0;
         rsp_gap <= 0;
         stall_done <= 1'b0;
      end else if (!stall_done && accepted_items == STALL_AT) begin
         stall_done <= 1'b1;
         stall_left <= STALL_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_chan.ready <= (stall_left == 1);
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_chan.ready <= (rsp_gap == 1);
      end else if (accepted_items < total_items - CALM_TAIL && $urandom_range(3) == 0) begin
         rsp_gap <= $urandom_range(11, 1);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // compare every response beat with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response beat: answer %0d", rsp_chan.answer);
         end else begin
            if (rsp_chan.answer !== pending_answers[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("answer mismatch: expected %0d, actual %0d",
                           pending_answers[0], rsp_chan.answer);
            end
            void'(pending_answers.pop_front());
         end
      end
   end

   // count cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("** mobius_divisor_sum_query: FAILED **");
         $finish;
      end
   end

   initial begin
      stim_row_type row;
      int wait_cycles;
      accepted_items = 0;
      total_items = directed_rows.size() + RANDOM_QUERIES;
      clear_tables();
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.command = CMD_QUERY;
      req_chan.first_bound = '0;
      req_chan.second_bound = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[r]) send_item(directed_rows[r]);
      // keep the short side small so each query stays cheap; the long side spans all bits
      for (int r = 0; r < RANDOM_QUERIES; r++) begin
         row.command = CMD_QUERY;
         row.known   = 1'b0;
         row.answer  = '0;
         row.n = $urandom_range(4) == 0 ? $urandom_range(64) : $urandom_range(12);
         row.m = $urandom_range(2) == 0 ? $urandom_range(20) : $urandom_range(17'h1ffff);
         if ($urandom_range(1)) begin
            row.n ^= row.m; row.m ^= row.n; row.n ^= row.m;
         end
         send_item(row);
      end
      req_chan.valid <= 1'b0;
      wait_cycles = 0;
      while (pending_answers.size() != 0 && wait_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_answers.size() == 0)
         $display("** mobius_divisor_sum_query: PASSED **");
      else
         $display("** mobius_divisor_sum_query: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/mds_pkg.sv
design/mds_if.sv
design/mds_ram.sv
design/mds_divider.sv
design/mds_datapath.sv
design/mds_ctrl.sv
design/mobius_divisor_sum_query.sv
verif/mobius_divisor_sum_query_test.sv
